>>> hw/rtl/psp_pkg.sv
// Shared types, widths and register codes of the partial shuffle sampler.
package psp_pkg;

	localparam int COUNT_W        = 17;
	localparam int INDEX_BITS_DEF = 16;
	localparam int RAND_BITS_DEF  = 31;
	localparam int RAND_FIELD_W   = 31;
	localparam int OUT_W          = 16;
	localparam int IN_DATA_W      = 32;
	localparam int OUT_DATA_W     = 2 * OUT_W;
	localparam int EPOCH_W        = 8;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_COUNT = CFG_IDX_W'(1);

	localparam logic [COUNT_W-1:0] TOTAL_COUNT_RST  = COUNT_W'(0);
	localparam logic [COUNT_W-1:0] SELECT_COUNT_RST = COUNT_W'(100);

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START1,
		ST_DIV1,
		ST_START2,
		ST_DIV2,
		ST_JCALC,
		ST_RD_I,
		ST_RD_J,
		ST_CAP_B,
		ST_WR_I,
		ST_WR_J,
		ST_OUT
	} psp_state_t;

endpackage

>>> hw/rtl/partial_shuffle_sampler.sv
// Top level of the partial shuffle sampler.
//
// Picks select_count distinct indices out of 0..total_count-1, one per draw beat,
// with total_count capped at the table size and select_count at total_count.
// Input channel s_axis: tuser is the mode (0 restart, 1 draw), tdata carries the
// random value. A restart gives no beat on m_axis. A draw runs two serial
// divisions through one shared bit-serial divider and then reads and swaps two
// table entries in the index RAM; no new beat is taken until the draw has
// passed its result to the output register. A draw past the last step gives no result.
// Output channel m_axis: tdata holds the index and its position, tlast marks
// the final index of the selection. The result sits in an output register, so
// a new beat is taken while it waits; a stalled receiver holds the block only
// once the next result is also ready.
// After reset and after every 255th restart the entry tag RAM is swept, one
// entry a cycle over all 2^INDEX_BITS entries, with s_axis_tready low;
// configuration writes on cfg_we/cfg_index/cfg_data are taken at any time.
module partial_shuffle_sampler #(
	parameter int INDEX_BITS = psp_pkg::INDEX_BITS_DEF,
	parameter int RAND_BITS  = psp_pkg::RAND_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [psp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psp_pkg::COUNT_W-1:0]      cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [psp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // random_value[30:0], pad
	input  logic                             s_axis_tuser,  // mode
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [psp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // selected_index, position
	output logic                             m_axis_tlast
);

	import psp_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int NW    = (INDEX_BITS + 1 > COUNT_W) ? INDEX_BITS + 1 : COUNT_W;
	localparam int DVW   = (RAND_BITS + 1 > NW) ? RAND_BITS + 1 : NW;
	localparam int CW    = (RAND_BITS > NW) ? RAND_BITS : NW;

	localparam logic [RAND_BITS-1:0] RAND_CEIL = {RAND_BITS{1'b1}};
	localparam logic [NW-1:0]        DEPTH_N   = NW'(1) << INDEX_BITS;

	psp_state_t state_q, state_d;

	logic [COUNT_W-1:0]    total_q, select_q, step_q;
	logic [EPOCH_W-1:0]    epoch_q;
	logic [INDEX_BITS-1:0] clr_addr_q;
	logic [RAND_BITS-1:0]  r_q;
	logic [INDEX_BITS-1:0] i_q, j_q, a_q, b_q;
	logic [NW-1:0]         n_q, span_q;
	logic [DVW-1:0]        d_q;
	logic                  last_q;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_sel_q, out_pos_q;
	logic                  out_last_q;

	logic                  in_acc, slot_free, productive;
	logic [NW-1:0]         n_eff, k_eff, step_n;

	logic                  div_start, div_done;
	logic [RAND_BITS-1:0]  div_dividend, div_quot;
	logic [DVW-1:0]        div_divisor;

	logic                  tag_we, val_we;
	logic [INDEX_BITS-1:0] waddr, raddr, wval, rval;
	logic [EPOCH_W-1:0]    wtag, rtag;
	logic [INDEX_BITS-1:0] entry;
	logic [CW-1:0]         q2_c, span_c;
	logic [INDEX_BITS-1:0] j_calc;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign slot_free = !out_valid_q || m_axis_tready;

	// saturate N to the table size, clamp K to N
	assign step_n     = NW'(step_q);
	assign n_eff      = (NW'(total_q) > DEPTH_N) ? DEPTH_N : NW'(total_q);
	assign k_eff      = (NW'(select_q) > n_eff) ? n_eff : NW'(select_q);
	assign productive = step_n < k_eff;

	// an entry with a stale tag reads as its own index
	assign entry = (rtag == epoch_q) ? rval : ((state_q == ST_RD_J) ? i_q : j_q);

	assign q2_c   = CW'(div_quot);
	assign span_c = CW'(span_q);
	assign j_calc = (q2_c >= span_c) ? INDEX_BITS'(n_q - NW'(1))
	                                 : INDEX_BITS'(CW'(i_q) + q2_c);

	psp_div #(
		.DW (RAND_BITS),
		.VW (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	psp_ram #(
		.WIDTH (INDEX_BITS),
		.DEPTH (DEPTH)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (waddr),
		.wdata (wval),
		.raddr (raddr),
		.rdata (rval)
	);

	psp_ram #(
		.WIDTH (EPOCH_W),
		.DEPTH (DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (waddr),
		.wdata (wtag),
		.raddr (raddr),
		.rdata (rtag)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == {INDEX_BITS{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (!s_axis_tuser) begin
						state_d = (epoch_q == EPOCH_LAST) ? ST_CLEAR : ST_IDLE;
					end else if (productive) begin
						state_d = ST_START1;
					end
				end
			end
			ST_START1: state_d = ST_DIV1;
			ST_DIV1: begin
				if (div_done) begin
					state_d = ST_START2;
				end
			end
			ST_START2: state_d = ST_DIV2;
			ST_DIV2: begin
				if (div_done) begin
					state_d = ST_JCALC;
				end
			end
			ST_JCALC: state_d = ST_RD_I;
			ST_RD_I:  state_d = ST_RD_J;
			ST_RD_J:  state_d = ST_CAP_B;
			ST_CAP_B: state_d = ST_WR_I;
			ST_WR_I:  state_d = ST_WR_J;
			ST_WR_J:  state_d = ST_OUT;
			ST_OUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		div_dividend  = RAND_CEIL;
		div_divisor   = DVW'(span_q);
		tag_we        = 1'b0;
		val_we        = 1'b0;
		waddr         = i_q;
		wval          = b_q;
		wtag          = epoch_q;
		raddr         = i_q;
		case (state_q)
			ST_CLEAR: begin
				tag_we = 1'b1;
				waddr  = clr_addr_q;
				wtag   = '0;
			end
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_START1: div_start = 1'b1;
			ST_START2: begin
				div_start    = 1'b1;
				div_dividend = r_q;
				div_divisor  = d_q;
			end
			ST_RD_J: raddr = j_q;
			ST_WR_I: begin
				tag_we = 1'b1;
				val_we = 1'b1;
			end
			ST_WR_J: begin
				tag_we = 1'b1;
				val_we = 1'b1;
				waddr  = j_q;
				wval   = a_q;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			epoch_q     <= EPOCH_FIRST;
			step_q      <= '0;
			total_q     <= TOTAL_COUNT_RST;
			select_q    <= SELECT_COUNT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_TOTAL_COUNT:  total_q  <= cfg_data;
					REG_SELECT_COUNT: select_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + INDEX_BITS'(1);
				if (clr_addr_q == {INDEX_BITS{1'b1}}) begin
					epoch_q <= EPOCH_FIRST;
				end
			end
			if (in_acc && !s_axis_tuser) begin
				step_q <= '0;
				if (epoch_q != EPOCH_LAST) begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
			if (state_q == ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
				step_q      <= step_q + COUNT_W'(1);
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// draw payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			r_q    <= RAND_BITS'(s_axis_tdata[RAND_FIELD_W-1:0]);
			i_q    <= INDEX_BITS'(step_q);
			n_q    <= n_eff;
			span_q <= n_eff - step_n;
			last_q <= (step_n + NW'(1)) == k_eff;
		end
		if (state_q == ST_DIV1 && div_done) begin
			d_q <= DVW'(div_quot) + DVW'(1);
		end
		if (state_q == ST_JCALC) begin
			j_q <= j_calc;
		end
		if (state_q == ST_RD_J) begin
			a_q <= entry;
		end
		if (state_q == ST_CAP_B) begin
			b_q <= entry;
		end
		if (state_q == ST_OUT && slot_free) begin
			out_sel_q  <= OUT_W'(b_q);
			out_pos_q  <= OUT_W'(i_q);
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_pos_q, out_sel_q};
	assign m_axis_tlast  = out_last_q;

endmodule

>>> hw/rtl/psp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/psp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module psp_div #(
	parameter int DW = 31,
	parameter int VW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    div_q;
	logic [DW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VW:0]   rem_shift;
	logic [VW:0]   rem_diff;
	logic          fits;
	logic [VW-1:0] rem_next;

	assign rem_shift = {rem_q, quo_q[DW-1]};
	assign rem_diff  = rem_shift - {1'b0, div_q};
	assign fits      = rem_shift >= {1'b0, div_q};
	assign rem_next  = fits ? rem_diff[VW-1:0] : rem_shift[VW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: load operands on start, shift one bit a cycle while busy
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/psp_checker.sv
// Port-level checks of the partial shuffle sampler, bound to the top level.
module psp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [psp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);

	// no beat is taken while reset is asserted
	a_no_ready_in_reset: assert property (@(posedge clk)
		!arst_n |-> !s_axis_tready)
		else $error("input ready during reset");

	// an accepted beat never yields a result in the very next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("result appeared one cycle after accept");

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output payload changed while stalled");

endmodule

bind partial_shuffle_sampler psp_checker u_psp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_top.sv
// Self-checking testbench for partial_shuffle_sampler: stream driver, monitor and shuffle predictor.
module tb_top;
	import psp_pkg::*;

	localparam logic MODE_RESTART = 1'b0;
	localparam logic MODE_DRAW    = 1'b1;

	localparam longint unsigned RAND_PEAK = (64'd1 << RAND_BITS_DEF) - 64'd1;
	localparam longint unsigned TAB_DEPTH = 64'd1 << INDEX_BITS_DEF;
	localparam int DRAIN_CYCLES = 2 * RAND_BITS_DEF + 64;
	localparam int CYCLE_LIMIT  = 10000000;
	localparam int ITEM_TARGET  = 2000;

	typedef struct packed {
		logic                    mode;
		logic [RAND_FIELD_W-1:0] rand_val;
	} draw_t;

	typedef struct packed {
		logic [OUT_W-1:0] idx;
		logic [OUT_W-1:0] pos;
		logic             last;
	} pick_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index     = '0;
	logic [COUNT_W-1:0]      cfg_data      = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
	logic                    s_axis_tuser  = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic                    m_axis_tlast;

	// shuffle predictor state
	logic [OUT_W-1:0]   order_tab [0:(1 << INDEX_BITS_DEF) - 1];
	int unsigned        tag_epoch [0:(1 << INDEX_BITS_DEF) - 1];
	int unsigned        cur_epoch = 1;
	logic [COUNT_W-1:0] step_ctr  = '0;
	logic [COUNT_W-1:0] tot_cnt   = TOTAL_COUNT_RST;
	logic [COUNT_W-1:0] sel_cnt   = SELECT_COUNT_RST;

	draw_t feed_q [$];
	pick_t pick_q [$];
	pick_t exp_pick;
	draw_t next_item;
	bit    s_taken    = 1'b0;
	bit    calm       = 1'b0;
	int    fail_count = 0;
	int    cycle_cnt  = 0;
	int    items_sent = 0;

	partial_shuffle_sampler u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// unwritten entries read as their own index
	function automatic logic [OUT_W-1:0] read_slot(input logic [OUT_W-1:0] p);
		return (tag_epoch[p] == cur_epoch) ? order_tab[p] : p;
	endfunction

	function automatic void write_slot(input logic [OUT_W-1:0] p, input logic [OUT_W-1:0] v);
		order_tab[p] = v;
		tag_epoch[p] = cur_epoch;
	endfunction

	function automatic void shuffle_step(input logic mode, input logic [RAND_FIELD_W-1:0] rv);
		longint unsigned n, k, i, d, j;
		logic [OUT_W-1:0] a, b;
		pick_t res;
		if (mode == MODE_RESTART) begin
			cur_epoch++;
			step_ctr = '0;
			return;
		end
		n = tot_cnt;
		if (n > TAB_DEPTH)
			n = TAB_DEPTH;
		k = sel_cnt;
		if (k > n)
			k = n;
		i = step_ctr;
		if (i >= k)
			return;
		d = RAND_PEAK / (n - i) + 64'd1;
		j = i + longint'(rv) / d;
		if (j >= n)
			j = n - 64'd1;
		a = read_slot(i[OUT_W-1:0]);
		b = read_slot(j[OUT_W-1:0]);
		write_slot(i[OUT_W-1:0], b);
		write_slot(j[OUT_W-1:0], a);
		res.idx  = b;
		res.pos  = i[OUT_W-1:0];
		res.last = (i + 64'd1 == k);
		pick_q.push_back(res);
		step_ctr = COUNT_W'(i + 64'd1);
	endfunction

	// accept input beats and predict
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			shuffle_step(s_axis_tuser, s_axis_tdata[RAND_FIELD_W-1:0]);
			s_taken = 1'b1;
		end
	end

	// driver: advance to the next pending beat once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_taken)) begin
			s_taken = 1'b0;
			if (feed_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
				next_item = feed_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= next_item.mode;
				s_axis_tdata  <= {1'b0, next_item.rand_val};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
	end

	// monitor
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pick_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual data %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				fail_count++;
			end else begin
				exp_pick = pick_q.pop_front();
				if (m_axis_tdata[OUT_W-1:0] !== exp_pick.idx) begin
					$display("%0t: selected_index expected %0d actual %0d",
						$time, exp_pick.idx, m_axis_tdata[OUT_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[OUT_DATA_W-1:OUT_W] !== exp_pick.pos) begin
					$display("%0t: position expected %0d actual %0d",
						$time, exp_pick.pos, m_axis_tdata[OUT_DATA_W-1:OUT_W]);
					fail_count++;
				end
				if (m_axis_tlast !== exp_pick.last) begin
					$display("%0t: last expected %b actual %b",
						$time, exp_pick.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_TOTAL_COUNT)
			tot_cnt = val;
		else if (idx == REG_SELECT_COUNT)
			sel_cnt = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_counts(input int n, input int k);
		write_reg(REG_TOTAL_COUNT, COUNT_W'(n));
		write_reg(REG_SELECT_COUNT, COUNT_W'(k));
	endtask

	task automatic push_item(input logic mode, input logic [RAND_FIELD_W-1:0] rv);
		draw_t it;
		it.mode     = mode;
		it.rand_val = rv;
		feed_q.push_back(it);
	endtask

	// wait for every beat to be taken and every result to arrive, then let the block settle
	task automatic drain();
		while (feed_q.size() != 0 || s_axis_tvalid || pick_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [RAND_FIELD_W-1:0] pick_rand();
		case ($urandom_range(7))
			0:       return '0;
			1:       return RAND_FIELD_W'(RAND_PEAK);
			2:       return RAND_FIELD_W'($urandom_range(255));
			default: return RAND_FIELD_W'($urandom);
		endcase
	endfunction

	initial begin
		int n, k, k_eff, draws, phase;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset counts: N is zero, so draws give nothing
		push_item(MODE_DRAW, '0);
		push_item(MODE_DRAW, RAND_FIELD_W'(RAND_PEAK));
		drain();

		set_counts(8, 8);
		push_item(MODE_RESTART, '0);
		push_item(MODE_DRAW, '0);
		push_item(MODE_DRAW, RAND_FIELD_W'(RAND_PEAK));
		push_item(MODE_DRAW, 31'h4000_0000);
		push_item(MODE_DRAW, 31'h0000_0001);
		push_item(MODE_DRAW, RAND_FIELD_W'(RAND_PEAK));
		push_item(MODE_DRAW, '0);
		push_item(MODE_DRAW, 31'h2AAA_AAAA);
		push_item(MODE_DRAW, 31'h5555_5555);
		push_item(MODE_DRAW, 31'h1234_5678);
		drain();

		set_counts(65536, 65536);
		push_item(MODE_RESTART, '0);
		push_item(MODE_DRAW, RAND_FIELD_W'(RAND_PEAK));
		push_item(MODE_DRAW, '0);
		drain();

		set_counts(5, 0);
		push_item(MODE_DRAW, 31'h7000_0000);
		drain();

		set_counts(1, 1);
		push_item(MODE_RESTART, '0);
		push_item(MODE_DRAW, RAND_FIELD_W'(RAND_PEAK));
		drain();

		// change counts mid-selection, no restart
		set_counts(20, 10);
		push_item(MODE_RESTART, '0);
		push_item(MODE_DRAW, 31'h6543_2100);
		push_item(MODE_DRAW, RAND_FIELD_W'(RAND_PEAK));
		push_item(MODE_DRAW, 31'h0F0F_0F0F);
		drain();
		set_counts(12, 4);
		push_item(MODE_DRAW, 31'h7FFF_0000);
		push_item(MODE_DRAW, 31'h0000_FFFF);
		drain();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = (phase >= 30 && phase < 45);
			case ($urandom_range(9))
				0: begin
					n = 65536;
					k = ($urandom_range(3) == 0) ? 65536 : $urandom_range(1, 40);
				end
				1: begin
					n = $urandom_range(65536);
					k = $urandom_range(40);
				end
				2: begin
					n = $urandom_range(3);
					k = $urandom_range(1) ? 0 : 65536;
				end
				3: begin
					n = $urandom_range(1, 16);
					k = 65536;
				end
				default: begin
					n = $urandom_range(1, 48);
					k = $urandom_range(n + 4);
				end
			endcase
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_TOTAL_COUNT : REG_SELECT_COUNT,
					COUNT_W'($urandom_range(1) ? n : k));
			else
				set_counts(n, k);
			k_eff = (sel_cnt > tot_cnt) ? tot_cnt : sel_cnt;
			if (k_eff > 65536)
				k_eff = 65536;
			draws = (k_eff > 40) ? $urandom_range(5, 40) : k_eff + $urandom_range(2);
			// occasionally carry on with the previous selection
			if ($urandom_range(7) != 0) begin
				push_item(MODE_RESTART, pick_rand());
				items_sent++;
			end
			for (int d = 0; d < draws; d++) begin
				if ($urandom_range(29) == 0) begin
					push_item(MODE_RESTART, pick_rand());
					items_sent++;
				end
				push_item(MODE_DRAW, pick_rand());
				items_sent++;
			end
			drain();
			phase++;
		end
		calm = 1'b0;
		drain();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
